// ===== hdl/boundary_run_count_map_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the boundary run count map core
// Shared concurrent property wrappers, clocked on aclk, reset on aresetn.
// ----------------------------------------------------------------------------
`ifndef BOUNDARY_RUN_COUNT_MAP_CORE_ASSERT_SVH
`define BOUNDARY_RUN_COUNT_MAP_CORE_ASSERT_SVH

// Same-cycle implication
`define BRCM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define BRCM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/brcm_pkg.sv =====
// ----------------------------------------------------------------------------
// brcm_pkg
// Constants, codes and shared types of the boundary run count map core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package brcm_pkg;

    localparam int MAX_WIDTH  = 128;
    localparam int MAX_HEIGHT = 128;
    localparam int COORD_W    = 7;
    localparam int DIM_W      = 8;
    localparam int ADDR_W     = 2 * COORD_W;
    localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
    localparam int COUNT_W    = 8;
    localparam int PASS_W     = 5;
    localparam int REACH_W    = 9;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_RUN  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    localparam logic [1:0] REG_FRAME_WIDTH   = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_SHRINK_PASSES = 2'd2;
    localparam logic [1:0] REG_SPREAD_MARGIN = 2'd3;

    localparam logic [DIM_W-1:0]  RST_FRAME_WIDTH   = 8'd128;
    localparam logic [DIM_W-1:0]  RST_FRAME_HEIGHT  = 8'd128;
    localparam logic [PASS_W-1:0] RST_SHRINK_PASSES = 5'd5;
    localparam logic [7:0]        RST_SPREAD_MARGIN = 8'd50;

    typedef struct packed {
        logic [ADDR_W-1:0]  label_raddr;
        logic               er_we;
        logic [ADDR_W-1:0]  er_waddr;
        logic               er_wdata;
        logic [ADDR_W-1:0]  er_raddr;
        logic               sc_we;
        logic [ADDR_W-1:0]  sc_waddr;
        logic               sc_wdata;
        logic [ADDR_W-1:0]  sc_raddr;
        logic               hmap_we;
        logic               vmap_we;
        logic [ADDR_W-1:0]  map_waddr;
        logic [COUNT_W-1:0] map_wdata;
        logic [ADDR_W-1:0]  map_raddr;
    } seq_mem_t;

    typedef struct packed {
        logic               label;
        logic               eroded;
        logic               scratch;
        logic [COUNT_W-1:0] hmap;
        logic [COUNT_W-1:0] vmap;
    } mem_rd_t;

    function automatic logic [ADDR_W-1:0] pix_addr(input logic [DIM_W-1:0] col,
                                                   input logic [DIM_W-1:0] row);
        return {row[COORD_W-1:0], col[COORD_W-1:0]};
    endfunction

endpackage

// ===== hdl/brcm_ram.sv =====
// ----------------------------------------------------------------------------
// brcm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module brcm_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/brcm_seq.sv =====
// ----------------------------------------------------------------------------
// brcm_seq
// Compute sequencer: mask copy, erosion passes, map clear and run fill.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module brcm_seq (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [brcm_pkg::DIM_W-1:0]   frame_w,
    input  logic [brcm_pkg::DIM_W-1:0]   frame_h,
    input  logic [brcm_pkg::PASS_W-1:0]  passes,
    input  logic [7:0]                   margin,
    input  brcm_pkg::mem_rd_t            rd_i,
    output brcm_pkg::seq_mem_t           mem_o,
    output logic                         busy,
    output logic                         done
);

    typedef enum logic [18:0] {
        S_IDLE      = 19'h00001,
        S_COPY_LE   = 19'h00002,
        S_COPY_ES   = 19'h00004,
        S_ERODE     = 19'h00008,
        S_CLEAR     = 19'h00010,
        S_F_RDA     = 19'h00020,
        S_F_RDB     = 19'h00040,
        S_F_CMP     = 19'h00080,
        S_CORE_RD   = 19'h00100,
        S_CORE_WR   = 19'h00200,
        S_BACK_CHK  = 19'h00400,
        S_BACK_RD   = 19'h00800,
        S_BACK_WR   = 19'h01000,
        S_FWD_CHK   = 19'h02000,
        S_FWD_RD    = 19'h04000,
        S_FWD_WR    = 19'h08000,
        S_RESUME    = 19'h10000,
        S_NEXT_LINE = 19'h20000,
        S_DONE      = 19'h40000
    } state_t;

    localparam int AW = brcm_pkg::ADDR_W;
    localparam int DW = brcm_pkg::DIM_W;
    localparam int RW = brcm_pkg::REACH_W;
    localparam logic [AW:0] SWEEP_END  = (AW + 1)'(brcm_pkg::DEPTH);
    localparam logic [AW:0] CLEAR_LAST = (AW + 1)'(brcm_pkg::DEPTH - 1);
    localparam logic [3:0]  NBR_LAST   = 4'd9;

    state_t state_reg, state_next;
    logic [AW:0]                   cnt_reg;
    logic [DW-1:0]                 x_reg, y_reg;
    logic [3:0]                    k_reg;
    logic                          acc_reg;
    logic [brcm_pkg::PASS_W-1:0]   pass_reg;
    logic                          sel_reg;
    logic [DW-1:0]                 l_reg, p_reg, start_reg, end_reg, q_reg;
    logic [RW-1:0]                 i_reg;
    logic                          in_run_reg, a_bit_reg;

    logic [DW-1:0]     lines, span, len;
    logic [RW-1:0]     reach;
    logic [RW:0]       fq;
    logic [AW-1:0]     cur_addr;
    logic [brcm_pkg::COUNT_W-1:0] map_rd;
    logic              diff;
    logic              raise;

    // pixel address of position p on line l
    function automatic logic [AW-1:0] fill_addr(input logic sel, input logic [DW-1:0] l,
                                                input logic [DW-1:0] p);
        logic [AW-1:0] a;
        if (sel) begin
            a = brcm_pkg::pix_addr(p, l);
        end else begin
            a = brcm_pkg::pix_addr(l, p);
        end
        return a;
    endfunction

    function automatic logic [AW-1:0] nbr_addr(input logic [DW-1:0] x, input logic [DW-1:0] y,
                                               input logic [3:0] k);
        logic [DW-1:0] nx, ny;
        case (k) inside
            4'd0, 4'd3, 4'd6: nx = x - 8'd1;
            4'd2, 4'd5, 4'd8: nx = x + 8'd1;
            default:          nx = x;
        endcase
        case (k) inside
            4'd0, 4'd1, 4'd2: ny = y - 8'd1;
            4'd6, 4'd7, 4'd8: ny = y + 8'd1;
            default:          ny = y;
        endcase
        return brcm_pkg::pix_addr(nx, ny);
    endfunction

    assign lines    = sel_reg ? (frame_h - 8'd1) : (frame_w - 8'd1);
    assign span     = sel_reg ? frame_w : frame_h;
    assign len      = end_reg - start_reg;
    assign reach    = {1'b0, margin} + {1'b0, len};
    assign fq       = {2'b00, end_reg} + {1'b0, i_reg} - 10'd1;
    assign cur_addr = fill_addr(sel_reg, l_reg, q_reg);
    assign map_rd   = sel_reg ? rd_i.vmap : rd_i.hmap;
    assign diff     = a_bit_reg ^ rd_i.label;
    assign raise    = map_rd < len;
    assign busy     = (state_reg != S_IDLE);
    assign done     = (state_reg == S_DONE);

    always_comb begin
        mem_o = '0;
        mem_o.label_raddr = fill_addr(sel_reg, l_reg, p_reg);
        mem_o.er_raddr    = cur_addr;
        mem_o.map_raddr   = cur_addr;
        mem_o.map_waddr   = cur_addr;
        mem_o.map_wdata   = len;
        unique case (state_reg)
            S_COPY_LE: begin
                mem_o.label_raddr = cnt_reg[AW-1:0];
                mem_o.er_we       = (cnt_reg != '0);
                mem_o.er_waddr    = AW'(cnt_reg - 1'b1);
                mem_o.er_wdata    = rd_i.label;
            end
            S_COPY_ES: begin
                mem_o.er_raddr = cnt_reg[AW-1:0];
                mem_o.sc_we    = (cnt_reg != '0);
                mem_o.sc_waddr = AW'(cnt_reg - 1'b1);
                mem_o.sc_wdata = rd_i.eroded;
            end
            S_ERODE: begin
                mem_o.sc_raddr = nbr_addr(x_reg, y_reg, k_reg);
                mem_o.er_we    = (k_reg == NBR_LAST);
                mem_o.er_waddr = brcm_pkg::pix_addr(x_reg, y_reg);
                mem_o.er_wdata = acc_reg & rd_i.scratch;
            end
            S_CLEAR: begin
                mem_o.hmap_we   = 1'b1;
                mem_o.vmap_we   = 1'b1;
                mem_o.map_waddr = cnt_reg[AW-1:0];
                mem_o.map_wdata = '0;
            end
            S_F_RDB: begin
                mem_o.label_raddr = fill_addr(sel_reg, l_reg + 8'd1, p_reg);
            end
            S_CORE_WR, S_BACK_WR, S_FWD_WR: begin
                if (raise && !(state_reg != S_CORE_WR && rd_i.eroded)) begin
                    mem_o.hmap_we = !sel_reg;
                    mem_o.vmap_we = sel_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:      if (start) state_next = S_COPY_LE;
            S_COPY_LE:   if (cnt_reg == SWEEP_END)
                             state_next = (passes == '0) ? S_CLEAR : S_COPY_ES;
            S_COPY_ES:   if (cnt_reg == SWEEP_END) state_next = S_ERODE;
            S_ERODE: begin
                if (k_reg == NBR_LAST && x_reg + 8'd1 == frame_w - 8'd1 &&
                    y_reg + 8'd1 == frame_h - 8'd1) begin
                    state_next = (pass_reg + 5'd1 == passes) ? S_CLEAR : S_COPY_ES;
                end
            end
            S_CLEAR:     if (cnt_reg == CLEAR_LAST) state_next = S_F_RDA;
            S_F_RDA:     state_next = S_F_RDB;
            S_F_RDB:     state_next = S_F_CMP;
            S_F_CMP: begin
                if (!in_run_reg) begin
                    if (diff && p_reg + 8'd1 == span) state_next = S_CORE_RD;
                    else if (p_reg + 8'd1 == span)   state_next = S_NEXT_LINE;
                    else                             state_next = S_F_RDA;
                end else begin
                    if (!diff || p_reg + 8'd1 == span) state_next = S_CORE_RD;
                    else                               state_next = S_F_RDA;
                end
            end
            S_CORE_RD:   state_next = S_CORE_WR;
            S_CORE_WR:   state_next = (q_reg + 8'd1 == end_reg) ? S_BACK_CHK : S_CORE_RD;
            S_BACK_CHK:  state_next = (i_reg >= reach || i_reg > {1'b0, start_reg}) ?
                                      S_FWD_CHK : S_BACK_RD;
            S_BACK_RD:   state_next = S_BACK_WR;
            S_BACK_WR:   state_next = rd_i.eroded ? S_FWD_CHK : S_BACK_CHK;
            S_FWD_CHK:   state_next = (i_reg >= reach || fq >= {2'b00, span}) ?
                                      S_RESUME : S_FWD_RD;
            S_FWD_RD:    state_next = S_FWD_WR;
            S_FWD_WR:    state_next = rd_i.eroded ? S_RESUME : S_FWD_CHK;
            S_RESUME:    state_next = (end_reg == span) ? S_NEXT_LINE : S_F_RDA;
            S_NEXT_LINE: state_next = (l_reg + 8'd1 == lines && sel_reg) ? S_DONE : S_F_RDA;
            S_DONE:      state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= '0;
            sel_reg    <= 1'b0;
            in_run_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    cnt_reg  <= '0;
                    pass_reg <= '0;
                end
                S_COPY_LE, S_COPY_ES: begin
                    if (cnt_reg == SWEEP_END) begin
                        cnt_reg <= '0;
                        x_reg   <= 8'd1;
                        y_reg   <= 8'd1;
                        k_reg   <= '0;
                        acc_reg <= 1'b1;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_ERODE: begin
                    if (k_reg == NBR_LAST) begin
                        k_reg   <= '0;
                        acc_reg <= 1'b1;
                        if (x_reg + 8'd1 == frame_w - 8'd1) begin
                            x_reg <= 8'd1;
                            if (y_reg + 8'd1 == frame_h - 8'd1) begin
                                y_reg    <= 8'd1;
                                pass_reg <= pass_reg + 5'd1;
                            end else begin
                                y_reg <= y_reg + 8'd1;
                            end
                        end else begin
                            x_reg <= x_reg + 8'd1;
                        end
                    end else begin
                        if (k_reg != '0) acc_reg <= acc_reg & rd_i.scratch;
                        k_reg <= k_reg + 4'd1;
                    end
                end
                S_CLEAR: begin
                    cnt_reg    <= cnt_reg + 1'b1;
                    sel_reg    <= 1'b0;
                    l_reg      <= '0;
                    p_reg      <= '0;
                    in_run_reg <= 1'b0;
                end
                S_F_RDB: a_bit_reg <= rd_i.label;
                S_F_CMP: begin
                    if (!in_run_reg) begin
                        if (diff) begin
                            start_reg  <= p_reg;
                            q_reg      <= p_reg;
                            in_run_reg <= 1'b1;
                            if (p_reg + 8'd1 == span) end_reg <= span;
                        end
                        if (p_reg + 8'd1 != span) p_reg <= p_reg + 8'd1;
                    end else begin
                        q_reg <= start_reg;
                        if (!diff) begin
                            end_reg <= p_reg;
                        end else if (p_reg + 8'd1 == span) begin
                            end_reg <= span;
                        end else begin
                            p_reg <= p_reg + 8'd1;
                        end
                    end
                end
                S_CORE_WR: begin
                    q_reg <= q_reg + 8'd1;
                    i_reg <= 9'd1;
                end
                S_BACK_CHK: begin
                    q_reg <= start_reg - i_reg[DW-1:0];
                    if (i_reg >= reach || i_reg > {1'b0, start_reg}) i_reg <= 9'd1;
                end
                S_BACK_WR: i_reg <= rd_i.eroded ? 9'd1 : i_reg + 9'd1;
                S_FWD_CHK: q_reg <= fq[DW-1:0];
                S_FWD_WR:  i_reg <= i_reg + 9'd1;
                S_RESUME: begin
                    in_run_reg <= 1'b0;
                    p_reg      <= end_reg;
                end
                S_NEXT_LINE: begin
                    p_reg <= '0;
                    if (l_reg + 8'd1 == lines) begin
                        l_reg   <= '0;
                        sel_reg <= 1'b1;
                    end else begin
                        l_reg <= l_reg + 8'd1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== hdl/boundary_run_count_map_core.sv =====
// ----------------------------------------------------------------------------
// boundary_run_count_map_core
// Mask store, eroded mask and horizontal/vertical run count maps.
// ----------------------------------------------------------------------------
// Channel   Dir  Signals                          Transfer
// s_axis    in   s_tvalid s_tready s_tdata s_tuser  one item per transfer
// m_axis    out  m_tvalid m_tready m_tdata m_tuser  one result per item
// cfg       in   cfg_valid cfg_ready cfg_index cfg_data  register write
//
// Load and read items pass through the transfer, then a RAM read into the
// output register. A compute item holds s_tready low through the mask copies
// and erosion passes, the map clear, then the run fill over the scanned pixel
// pairs, the run pixels and the spread pixels.
// Reset is synchronous; maps read as zero until the first compute.
// A stalled m_tready blocks input once the output register is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "boundary_run_count_map_core_assert.svh"

module boundary_run_count_map_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // col[6:0], row[13:7], inside_req[14], zero
    input  logic [1:0]  s_tuser,   // operation[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // hcount[7:0], vcount[15:8],
                                   // eroded_inside[16], zero
    output logic        m_tuser,   // done_res[0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int AW = brcm_pkg::ADDR_W;
    localparam int CW = brcm_pkg::COUNT_W;
    localparam logic [7:0] MAX_W = 8'(brcm_pkg::MAX_WIDTH);
    localparam logic [7:0] MAX_H = 8'(brcm_pkg::MAX_HEIGHT);

    logic [7:0]                  frame_width_reg, frame_height_reg, spread_margin_reg;
    logic [brcm_pkg::PASS_W-1:0] shrink_passes_reg;
    logic [7:0]                  w, h;
    logic [brcm_pkg::COORD_W-1:0] col, row;
    logic [1:0]                  op;
    logic                        s_xfer, in_frame;
    logic [AW-1:0]               s_addr;
    logic                        pend_reg, pend_rd_reg, computed_reg;
    logic                        m_valid_reg, m_user_reg;
    logic [CW-1:0]               m_h_reg, m_v_reg;
    logic                        m_e_reg;

    brcm_pkg::seq_mem_t seq_mem;
    brcm_pkg::mem_rd_t  rd;
    logic               seq_busy, seq_done, seq_start;

    assign op       = s_tuser;
    assign col      = s_tdata[6:0];
    assign row      = s_tdata[13:7];
    assign w        = (frame_width_reg < 8'd3) ? 8'd3 :
                      (frame_width_reg > MAX_W) ? MAX_W : frame_width_reg;
    assign h        = (frame_height_reg < 8'd3) ? 8'd3 :
                      (frame_height_reg > MAX_H) ? MAX_H : frame_height_reg;
    assign in_frame = ({1'b0, col} < w) && ({1'b0, row} < h);
    assign s_addr   = brcm_pkg::pix_addr({1'b0, col}, {1'b0, row});
    assign s_tready = !seq_busy && !pend_reg && (!m_valid_reg || m_tready);
    assign s_xfer   = s_tvalid && s_tready;
    assign seq_start = s_xfer && (op == brcm_pkg::OP_RUN);
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg   <= brcm_pkg::RST_FRAME_WIDTH;
            frame_height_reg  <= brcm_pkg::RST_FRAME_HEIGHT;
            shrink_passes_reg <= brcm_pkg::RST_SHRINK_PASSES;
            spread_margin_reg <= brcm_pkg::RST_SPREAD_MARGIN;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                brcm_pkg::REG_FRAME_WIDTH:   frame_width_reg   <= cfg_data;
                brcm_pkg::REG_FRAME_HEIGHT:  frame_height_reg  <= cfg_data;
                brcm_pkg::REG_SHRINK_PASSES: shrink_passes_reg <= cfg_data[4:0];
                brcm_pkg::REG_SPREAD_MARGIN: spread_margin_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    brcm_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (seq_start),
        .frame_w (w),
        .frame_h (h),
        .passes  (shrink_passes_reg),
        .margin  (spread_margin_reg),
        .rd_i    (rd),
        .mem_o   (seq_mem),
        .busy    (seq_busy),
        .done    (seq_done)
    );

    brcm_ram #(.WIDTH(1), .DEPTH(brcm_pkg::DEPTH)) u_label (
        .aclk  (aclk),
        .we    (s_xfer && op == brcm_pkg::OP_LOAD && in_frame),
        .waddr (s_addr),
        .wdata (s_tdata[14]),
        .raddr (seq_mem.label_raddr),
        .rdata (rd.label)
    );

    brcm_ram #(.WIDTH(1), .DEPTH(brcm_pkg::DEPTH)) u_eroded (
        .aclk  (aclk),
        .we    (seq_mem.er_we),
        .waddr (seq_mem.er_waddr),
        .wdata (seq_mem.er_wdata),
        .raddr (seq_busy ? seq_mem.er_raddr : s_addr),
        .rdata (rd.eroded)
    );

    brcm_ram #(.WIDTH(1), .DEPTH(brcm_pkg::DEPTH)) u_scratch (
        .aclk  (aclk),
        .we    (seq_mem.sc_we),
        .waddr (seq_mem.sc_waddr),
        .wdata (seq_mem.sc_wdata),
        .raddr (seq_mem.sc_raddr),
        .rdata (rd.scratch)
    );

    brcm_ram #(.WIDTH(CW), .DEPTH(brcm_pkg::DEPTH)) u_hmap (
        .aclk  (aclk),
        .we    (seq_mem.hmap_we),
        .waddr (seq_mem.map_waddr),
        .wdata (seq_mem.map_wdata),
        .raddr (seq_busy ? seq_mem.map_raddr : s_addr),
        .rdata (rd.hmap)
    );

    brcm_ram #(.WIDTH(CW), .DEPTH(brcm_pkg::DEPTH)) u_vmap (
        .aclk  (aclk),
        .we    (seq_mem.vmap_we),
        .waddr (seq_mem.map_waddr),
        .wdata (seq_mem.map_wdata),
        .raddr (seq_busy ? seq_mem.map_raddr : s_addr),
        .rdata (rd.vmap)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg     <= 1'b0;
            pend_rd_reg  <= 1'b0;
            computed_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            pend_reg    <= s_xfer && (op != brcm_pkg::OP_RUN);
            pend_rd_reg <= s_xfer && (op == brcm_pkg::OP_READ) && in_frame;
            if (seq_start) computed_reg <= 1'b1;
            if (seq_done) begin
                m_valid_reg <= 1'b1;
                m_user_reg  <= 1'b1;
                m_h_reg     <= '0;
                m_v_reg     <= '0;
                m_e_reg     <= 1'b0;
            end else if (pend_reg) begin
                // result of a load, read or unused code: RAM data lands now
                m_valid_reg <= 1'b1;
                m_user_reg  <= 1'b0;
                m_h_reg     <= (pend_rd_reg && computed_reg) ? rd.hmap : '0;
                m_v_reg     <= (pend_rd_reg && computed_reg) ? rd.vmap : '0;
                m_e_reg     <= pend_rd_reg & rd.eroded;
            end else if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_e_reg, m_v_reg, m_h_reg};
    assign m_tuser  = m_user_reg;

    `BRCM_ASSERT_NOW(a_done_slot_free, seq_done, !m_valid_reg, "compute ended with output full")
    `BRCM_ASSERT_NEXT(a_run_starts, seq_start, seq_busy, "compute transfer did not start sequencer")
    `BRCM_ASSERT_NEXT(a_pend_delivers, pend_reg, m_valid_reg, "pending result not registered")
    `BRCM_ASSERT_NOW(a_no_pend_in_run, seq_busy, !pend_reg, "item pending during compute")

endmodule

// ===== verif/boundary_run_count_map_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boundary_run_count_map_core_tb
// Loads masks into small and edge-sized frames, runs the erosion and
// run-count computation, and reads the maps back. A behavioral model of the
// masks and count maps predicts every result, and each result is checked
// field by field.
// ----------------------------------------------------------------------------
module boundary_run_count_map_core_tb;

    typedef struct {
        logic [7:0] hcount;
        logic [7:0] vcount;
        logic       eroded;
        logic       done;
    } count_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;

    // frame registers as the block sees them
    int unsigned frame_w_reg = brcm_pkg::RST_FRAME_WIDTH;
    int unsigned frame_h_reg = brcm_pkg::RST_FRAME_HEIGHT;
    int unsigned passes_reg  = brcm_pkg::RST_SHRINK_PASSES;
    int unsigned margin_reg  = brcm_pkg::RST_SPREAD_MARGIN;

    bit         label_px  [0:brcm_pkg::DEPTH-1];
    bit         eroded_px [0:brcm_pkg::DEPTH-1];
    bit         scratch_px[0:brcm_pkg::DEPTH-1];
    bit [7:0]   hcount_px [0:brcm_pkg::DEPTH-1];
    bit [7:0]   vcount_px [0:brcm_pkg::DEPTH-1];

    count_result_t pending_counts[$];
    int errors = 0;
    int items_sent = 0;
    int results_seen = 0;
    int computes_run = 0;
    int burst_left = 0;
    int stall_mode = 0;
    int stall_cnt = 0;

    boundary_run_count_map_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
        if (v < 3) return 3;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void raise_count(bit horiz, int idx, int unsigned v);
        if (horiz) begin
            if (hcount_px[idx] < v) hcount_px[idx] = v[7:0];
        end else begin
            if (vcount_px[idx] < v) vcount_px[idx] = v[7:0];
        end
    endfunction

    function automatic void erode_mask(int w, int h);
        eroded_px = label_px;
        for (int pass = 0; pass < passes_reg; pass++) begin
            scratch_px = eroded_px;
            for (int y = 1; y + 1 < h; y++) begin
                for (int x = 1; x + 1 < w; x++) begin
                    int c;
                    bit all_in;
                    c = y * brcm_pkg::MAX_WIDTH + x;
                    if (!scratch_px[c]) continue;
                    all_in = 1'b1;
                    for (int dy = -1; dy <= 1; dy++)
                        for (int dx = -1; dx <= 1; dx++)
                            if (!scratch_px[c + dy * brcm_pkg::MAX_WIDTH + dx]) all_in = 1'b0;
                    if (!all_in) eroded_px[c] = 1'b0;
                end
            end
        end
    endfunction

    // scan lines of pixel pairs; raise each run's pixels to its length and spread it
    function automatic void fill_runs(bit horiz, int lines, int span, int line_step,
                                      int pos_step, int pair_off);
        for (int l = 0; l < lines; l++) begin
            int base, p, start, stop, len, reach, q;
            base = l * line_step;
            p = 0;
            while (p < span) begin
                if (label_px[base + p * pos_step] == label_px[base + p * pos_step + pair_off]) begin
                    p++;
                    continue;
                end
                start = p;
                while (p < span && label_px[base + p * pos_step] !=
                                   label_px[base + p * pos_step + pair_off])
                    p++;
                stop = p;
                len = stop - start;
                reach = margin_reg + len;
                for (q = start; q < stop; q++) raise_count(horiz, base + q * pos_step, len);
                for (int i = 1; i < reach; i++) begin
                    if (i > start) break;
                    q = start - i;
                    if (eroded_px[base + q * pos_step]) break;
                    raise_count(horiz, base + q * pos_step, len);
                end
                for (int i = 1; i < reach; i++) begin
                    q = stop + i - 1;
                    if (q >= span) break;
                    if (eroded_px[base + q * pos_step]) break;
                    raise_count(horiz, base + q * pos_step, len);
                end
            end
        end
    endfunction

    function automatic count_result_t predict_counts(logic [1:0] op, int col, int row,
                                                     bit inside_bit);
        count_result_t r;
        int w, h;
        w = clamp_dim(frame_w_reg, brcm_pkg::MAX_WIDTH);
        h = clamp_dim(frame_h_reg, brcm_pkg::MAX_HEIGHT);
        r = '{8'd0, 8'd0, 1'b0, 1'b0};
        case (op)
            brcm_pkg::OP_LOAD: begin
                if (col < w && row < h) label_px[row * brcm_pkg::MAX_WIDTH + col] = inside_bit;
            end
            brcm_pkg::OP_RUN: begin
                erode_mask(w, h);
                for (int i = 0; i < brcm_pkg::DEPTH; i++) begin
                    hcount_px[i] = '0;
                    vcount_px[i] = '0;
                end
                fill_runs(1'b1, w - 1, h, 1, brcm_pkg::MAX_WIDTH, 1);
                fill_runs(1'b0, h - 1, w, brcm_pkg::MAX_WIDTH, 1, brcm_pkg::MAX_WIDTH);
                r.done = 1'b1;
            end
            brcm_pkg::OP_READ: begin
                if (col < w && row < h) begin
                    r.hcount = hcount_px[row * brcm_pkg::MAX_WIDTH + col];
                    r.vcount = vcount_px[row * brcm_pkg::MAX_WIDTH + col];
                    r.eroded = eroded_px[row * brcm_pkg::MAX_WIDTH + col];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report(input string what, input int got, input int want);
        $display("[%0t] mismatch %s: got %0d expected %0d", $time, what, got, want);
        errors++;
    endtask

    // sender: bursts of random length separated by random gaps
    task automatic send_item(input logic [1:0] op, input int col, input int row,
                             input bit inside_bit);
        count_result_t r;
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, inside_bit, row[6:0], col[6:0]};
        do @(posedge aclk); while (!s_tready);
        r = predict_counts(op, col, row, inside_bit);
        pending_counts = {pending_counts, r};
        items_sent++;
        if (op == brcm_pkg::OP_RUN) computes_run++;
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_counts.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            brcm_pkg::REG_FRAME_WIDTH:   frame_w_reg = value;
            brcm_pkg::REG_FRAME_HEIGHT:  frame_h_reg = value;
            brcm_pkg::REG_SHRINK_PASSES: passes_reg  = value[4:0];
            brcm_pkg::REG_SPREAD_MARGIN: margin_reg  = value;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_frame(input int w, input int h, input int passes, input int margin);
        write_reg(brcm_pkg::REG_FRAME_WIDTH, w[7:0]);
        write_reg(brcm_pkg::REG_FRAME_HEIGHT, h[7:0]);
        write_reg(brcm_pkg::REG_SHRINK_PASSES, passes[7:0]);
        write_reg(brcm_pkg::REG_SPREAD_MARGIN, margin[7:0]);
    endtask

    // fill the whole frame: a random rectangle of inside with sparse noise
    task automatic load_frame_mask();
        int w, h, x0, x1, y0, y1;
        bit inside_bit;
        w = clamp_dim(frame_w_reg, brcm_pkg::MAX_WIDTH);
        h = clamp_dim(frame_h_reg, brcm_pkg::MAX_HEIGHT);
        x0 = $urandom_range(0, w - 1);
        x1 = $urandom_range(x0, w - 1);
        y0 = $urandom_range(0, h - 1);
        y1 = $urandom_range(y0, h - 1);
        for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x++) begin
                inside_bit = (x >= x0 && x <= x1 && y >= y0 && y <= y1);
                if ($urandom_range(0, 7) == 0) inside_bit = !inside_bit;
                send_item(brcm_pkg::OP_LOAD, x, y, inside_bit);
            end
    endtask

    task automatic test_directed_extremes();
        set_frame(3, 3, 31, 0);
        // out-of-frame loads and reads, and the unused code
        send_item(brcm_pkg::OP_LOAD, 127, 127, 1'b1);
        send_item(brcm_pkg::OP_LOAD, 127, 0, 1'b0);
        send_item(brcm_pkg::OP_LOAD, 0, 127, 1'b1);
        send_item(2'd3, 127, 127, 1'b1);
        send_item(brcm_pkg::OP_READ, 127, 127, 1'b0);
        send_item(brcm_pkg::OP_READ, 3, 0, 1'b0);
        load_frame_mask();
        send_item(brcm_pkg::OP_RUN, 0, 0, 1'b0);
        for (int y = 0; y < 3; y++)
            for (int x = 0; x < 3; x++) send_item(brcm_pkg::OP_READ, x, y, 1'b0);
        send_item(brcm_pkg::OP_READ, 0, 3, 1'b0);
        send_item(2'd3, 0, 0, 1'b0);
    endtask

    task automatic test_frame_phase(input int w, input int h, input int passes,
                                    input int margin, input int reads);
        int cw, ch;
        set_frame(w, h, passes, margin);
        cw = clamp_dim(w, brcm_pkg::MAX_WIDTH);
        ch = clamp_dim(h, brcm_pkg::MAX_HEIGHT);
        load_frame_mask();
        send_item(brcm_pkg::OP_RUN, $urandom_range(0, 127), $urandom_range(0, 127),
                  $urandom_range(0, 1));
        for (int i = 0; i < reads; i++)
            send_item(brcm_pkg::OP_READ, $urandom_range(0, cw - 1), $urandom_range(0, ch - 1),
                      1'b0);
    endtask

    // recompute over the mask already loaded, with new settings
    task automatic test_rerun(input int w, input int h, input int passes,
                              input int margin, input int reads);
        int cw, ch;
        set_frame(w, h, passes, margin);
        cw = clamp_dim(w, brcm_pkg::MAX_WIDTH);
        ch = clamp_dim(h, brcm_pkg::MAX_HEIGHT);
        send_item(brcm_pkg::OP_RUN, $urandom_range(0, 127), $urandom_range(0, 127),
                  $urandom_range(0, 1));
        for (int i = 0; i < reads; i++)
            send_item(brcm_pkg::OP_READ, $urandom_range(0, cw - 1), $urandom_range(0, ch - 1),
                      1'b0);
    endtask

    task automatic test_random_mix(input int count);
        int cw, ch, sel, col, row;
        cw = clamp_dim(frame_w_reg, brcm_pkg::MAX_WIDTH);
        ch = clamp_dim(frame_h_reg, brcm_pkg::MAX_HEIGHT);
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(0, 99);
            if ($urandom_range(0, 9) < 7) begin
                col = $urandom_range(0, cw - 1);
                row = $urandom_range(0, ch - 1);
            end else begin
                col = $urandom_range(0, 127);
                row = $urandom_range(0, 127);
            end
            if (i == count / 2)
                send_item(brcm_pkg::OP_RUN, col, row, $urandom_range(0, 1));
            else if (sel < 40)
                send_item(brcm_pkg::OP_LOAD, col, row, $urandom_range(0, 1));
            else if (sel < 95)
                send_item(brcm_pkg::OP_READ, col, row, $urandom_range(0, 1));
            else
                send_item(2'd3, col, row, $urandom_range(0, 1));
        end
    endtask

    // receiver stall pattern: modes of free flow, light and heavy stalls
    always @(negedge aclk) begin
        if (stall_cnt == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_cnt = $urandom_range(16, 96);
        end
        stall_cnt--;
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 1) == 0);
            default: m_tready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            count_result_t want;
            results_seen++;
            if (pending_counts.size() == 0) begin
                $display("[%0t] result transfer with nothing expected", $time);
                errors++;
            end else begin
                want = pending_counts.pop_front();
                if (m_tdata[7:0] !== want.hcount) report("hcount", m_tdata[7:0], want.hcount);
                if (m_tdata[15:8] !== want.vcount) report("vcount", m_tdata[15:8], want.vcount);
                if (m_tdata[16] !== want.eroded) report("eroded_inside", m_tdata[16], want.eroded);
                if (m_tuser !== want.done) report("done_res", m_tuser, want.done);
            end
        end
    end

    initial begin
        #200_000_000;
        $display("timeout waiting on the block");
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed_extremes();
        test_frame_phase(128, 3, 0, 255, 10);
        test_rerun(128, 3, 31, 3, 10);
        // out-of-range sizes saturate to 128 x 3
        test_rerun(200, 0, 5, 50, 10);
        test_frame_phase(3, 20, 2, 1, 10);
        test_random_mix(40);
        wait_drained();
        repeat (20) @(posedge aclk);
        if (pending_counts.size() != 0) begin
            $display("%0d results never arrived", pending_counts.size());
            errors++;
        end
        $display("covered %0d items, %0d computes, %0d results; frames 3x3, 128x3, 3x20",
                 items_sent, computes_run, results_seen);
        $display("saturated sizes, passes 0 to 31, margin 0 to 255, %0d mismatches", errors);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
